>>> rtl/core/sfmh_pkg.sv
`timescale 1ns / 1ps
package sfmh_pkg;
  localparam int CAPACITY_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH = 32;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_SORT = 2'd2,
    REQ_ALT  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_POP_OK   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [FIELD_WIDTH-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] pop_value;
    logic [1:0]             status;
  } out_word_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,      // write fifo tail
    OP_FRD,       // read fifo head
    OP_FPOP,      // latch fifo head into out, advance
    OP_HRD_TOP,   // read heap root and last
    OP_HTOP_LAT,  // latch root, start sift down
    OP_HLAST_LAT, // latch last value
    OP_SD_RD,     // read both children
    OP_SD_STEP,   // compare, move child up or finish
    OP_INS_LAT,   // take fifo head as insert value, advance fifo
    OP_SU_RD,     // read parent
    OP_SU_STEP,   // compare, move parent down or finish
    OP_RES_EMPTY,
    OP_RES_FULL,
    OP_RES_ACC
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic fifo_empty;
    logic heap_empty;
    logic heap_full;
    logic total_full;
    logic heap_one;  // heap holds a single entry
    logic sd_done;   // sift down finished this step
    logic su_done;   // sift up finished this step
  } sts_t;
endpackage

>>> rtl/core/sfmh_ram.sv
`timescale 1ns / 1ps
module sfmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

>>> rtl/core/sfmh_datapath.sv
`timescale 1ns / 1ps
module sfmh_datapath #(
  parameter int CAPACITY = sfmh_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = sfmh_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sfmh_pkg::cmd_t     cmd,
  input  sfmh_pkg::in_word_t in_word,
  output sfmh_pkg::sts_t     sts,
  output sfmh_pkg::out_word_t res
);
  import sfmh_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  logic [AW-1:0] fifo_head;
  logic [CW-1:0] fifo_count;
  logic [CW-1:0] heap_count;
  logic [IW-1:0] idx;
  logic [VALUE_WIDTH-1:0] hold;

  // fifo ram
  logic f_we;
  logic [AW-1:0] f_waddr, f_raddr;
  logic [VALUE_WIDTH-1:0] f_wdata, f_rdata, f_unused;

  // heap ram, port a root/child/parent, port b last entry/second child
  logic h_we;
  logic [AW-1:0] h_waddr, h_ra, h_rb;
  logic [VALUE_WIDTH-1:0] h_wdata, h_qa, h_qb;

  logic [IW-1:0] left, right, parent;
  logic [CW+1:0] tail_sum;
  logic [CW+1:0] tail_wrap;
  logic right_ok, pick_right, left_ok;
  logic [VALUE_WIDTH-1:0] pick_val;
  logic [IW-1:0] pick_idx;
  logic [VALUE_WIDTH-1:0] in_val;

  assign in_val = VALUE_WIDTH'(in_word.push_value);
  assign left   = IW'({idx, 1'b1});
  assign right  = left + IW'(1);
  assign parent = (idx - IW'(1)) >> 1;
  assign left_ok  = {2'b00, left} < (IW+2)'(heap_count);
  assign right_ok = {2'b00, right} < (IW+2)'(heap_count);
  assign pick_right = right_ok && (h_qb < h_qa);
  assign pick_val = pick_right ? h_qb : h_qa;
  assign pick_idx = pick_right ? right : left;
  assign tail_sum = (CW+2)'(fifo_head) + (CW+2)'(fifo_count);
  // head plus count stays below twice the capacity, so one subtract wraps it
  assign tail_wrap = (tail_sum >= (CW+2)'(CAPACITY)) ? tail_sum - (CW+2)'(CAPACITY) : tail_sum;

  always_comb begin
    f_we = 1'b0;
    f_waddr = AW'(tail_wrap);
    f_wdata = in_val;
    f_raddr = fifo_head;
    h_we = 1'b0;
    h_waddr = idx[AW-1:0];
    h_wdata = hold;
    h_ra = left[AW-1:0];
    h_rb = right[AW-1:0];
    case (cmd.op)
      OP_PUSH: f_we = 1'b1;
      OP_HRD_TOP: begin
        h_ra = '0;
        h_rb = AW'(heap_count - CW'(1));
      end
      OP_SD_STEP: begin
        if (left_ok && pick_val < hold) begin
          h_we = 1'b1;
          h_wdata = pick_val;
        end else begin
          h_we = 1'b1;
        end
      end
      OP_SU_RD: h_ra = parent[AW-1:0];
      OP_SU_STEP: begin
        h_we = 1'b1;
        if (idx != '0 && h_qa > hold) begin
          h_wdata = h_qa;
        end
      end
      default: ;
    endcase
  end

  sfmh_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_fifo_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr_a(f_raddr), .rdata_a(f_rdata), .raddr_b(f_raddr), .rdata_b(f_unused)
  );

  sfmh_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_heap_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr_a(h_ra), .rdata_a(h_qa), .raddr_b(h_rb), .rdata_b(h_qb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head <= '0;
      fifo_count <= '0;
      heap_count <= '0;
    end else begin
      case (cmd.op)
        OP_PUSH: begin
          fifo_count <= fifo_count + CW'(1);
          res.status <= ST_ACCEPTED;
          res.pop_value <= '0;
        end
        OP_FPOP: begin
          res.pop_value <= FIELD_WIDTH'(f_rdata);
          res.status <= ST_POP_OK;
          fifo_head <= (fifo_head == AW'(CAPACITY - 1)) ? '0 : fifo_head + AW'(1);
          fifo_count <= fifo_count - CW'(1);
        end
        OP_HTOP_LAT: begin
          res.pop_value <= FIELD_WIDTH'(h_qa);
          res.status <= ST_POP_OK;
          hold <= h_qb;
          heap_count <= heap_count - CW'(1);
          idx <= '0;
        end
        OP_SD_STEP: begin
          if (left_ok && pick_val < hold) begin
            idx <= pick_idx;
          end
        end
        OP_INS_LAT: begin
          hold <= f_rdata;
          idx <= IW'(heap_count);
          heap_count <= heap_count + CW'(1);
          fifo_head <= (fifo_head == AW'(CAPACITY - 1)) ? '0 : fifo_head + AW'(1);
          fifo_count <= fifo_count - CW'(1);
        end
        OP_SU_STEP: begin
          if (idx != '0 && h_qa > hold) begin
            idx <= parent;
          end
        end
        OP_RES_EMPTY: begin
          res.pop_value <= '0;
          res.status <= ST_EMPTY;
        end
        OP_RES_FULL: begin
          res.pop_value <= '0;
          res.status <= ST_FULL;
        end
        OP_RES_ACC: begin
          res.pop_value <= '0;
          res.status <= ST_ACCEPTED;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.fifo_empty = fifo_count == '0;
    sts.heap_empty = heap_count == '0;
    sts.heap_full  = heap_count == CW'(CAPACITY);
    sts.total_full = ({1'b0, fifo_count} + {1'b0, heap_count}) >= (CW+1)'(CAPACITY);
    sts.heap_one   = heap_count == CW'(1);
    sts.sd_done    = !(left_ok && pick_val < hold);
    sts.su_done    = !(idx != '0 && h_qa > hold);
  end
endmodule

>>> rtl/core/sfmh_ctrl.sv
`timescale 1ns / 1ps
module sfmh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     req_type,
  output logic           out_valid,
  input  logic           out_stall,
  input  sfmh_pkg::sts_t sts,
  output sfmh_pkg::cmd_t cmd
);
  import sfmh_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_FRD     = 12'b000000000010,
    S_FPOP    = 12'b000000000100,
    S_HRD     = 12'b000000001000,
    S_HLAT    = 12'b000000010000,
    S_SDRD    = 12'b000000100000,
    S_SDSTEP  = 12'b000001000000,
    S_SORT    = 12'b000010000000,
    S_IRD     = 12'b000100000000,
    S_SURD    = 12'b001000000000,
    S_SUSTEP  = 12'b010000000000,
    S_OUT     = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic acc;

  assign in_stall = state != S_IDLE;
  assign acc = in_valid && state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = S_OUT;
          case (req_type)
            REQ_PUSH: cmd.op = sts.total_full ? OP_RES_FULL : OP_PUSH;
            REQ_POP: begin
              if (!sts.heap_empty) state_next = S_HRD;
              else if (!sts.fifo_empty) state_next = S_FRD;
              else cmd.op = OP_RES_EMPTY;
            end
            default: state_next = S_SORT;
          endcase
        end
      end
      S_FRD: state_next = S_FPOP;
      S_FPOP: begin
        cmd.op = OP_FPOP;
        state_next = S_OUT;
      end
      S_HRD: begin
        cmd.op = OP_HRD_TOP;
        state_next = S_HLAT;
      end
      S_HLAT: begin
        cmd.op = OP_HTOP_LAT;
        state_next = sts.heap_one ? S_OUT : S_SDRD;
      end
      S_SDRD: begin
        cmd.op = OP_SD_RD;
        state_next = S_SDSTEP;
      end
      S_SDSTEP: begin
        cmd.op = OP_SD_STEP;
        state_next = sts.sd_done ? S_OUT : S_SDRD;
      end
      S_SORT: begin
        if (sts.fifo_empty || sts.heap_full) begin
          cmd.op = OP_RES_ACC;
          state_next = S_OUT;
        end else begin
          state_next = S_IRD;
        end
      end
      S_IRD: begin
        cmd.op = OP_INS_LAT;
        state_next = S_SURD;
      end
      S_SURD: begin
        cmd.op = OP_SU_RD;
        state_next = S_SUSTEP;
      end
      S_SUSTEP: begin
        cmd.op = OP_SU_STEP;
        state_next = sts.su_done ? S_SORT : S_SURD;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

>>> rtl/core/staged_fifo_min_heap_queue.sv
`timescale 1ns / 1ps
// fifo plus binary min-heap sharing one capacity; one word in, one result word out.
// a push is answered at once; a fifo pop reads and then latches the fifo head; a heap
// pop reads root and last, latches the root, then sifts down (at most one step per
// level); a sort moves fifo entries into the heap one by one, each sifted up until
// it settles; each heap step costs one ram read then one compare/write, and
// one word is worked on at a time, held in the result register until taken
module staged_fifo_min_heap_queue #(
  parameter int CAPACITY = sfmh_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = sfmh_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfmh_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sfmh_pkg::out_word_t out_data
);
  import sfmh_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  sfmh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(in_data.req_type), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  // storage, pointers and the result register
  sfmh_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(in_data), .sts(sts), .res(out_data)
  );
endmodule

>>> rtl/core/sfmh_checker.sv
`timescale 1ns / 1ps
module sfmh_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input sfmh_pkg::out_word_t out_data
);
  import sfmh_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_zero_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_POP_OK |-> out_data.pop_value == '0)
    else $error("non-pop result carries a value");
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid) else $error("result repeated");
endmodule

bind staged_fifo_min_heap_queue sfmh_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sfmh_pkg::*;

  localparam int CAP = 1024;
  localparam int TAIL_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  always #5 clk = ~clk;

  staged_fifo_min_heap_queue i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // shadow copy of the block's two stores
  logic [31:0] fifo_q[$];
  logic [31:0] heap_q[$];

  // expected result words, oldest first
  out_word_t expected_q[$];
  // words waiting to be driven
  in_word_t pending_q[$];

  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int full_seen = 0;
  int empty_seen = 0;
  bit quiet = 1'b0;   // no idling on either side while set
  bit hold = 1'b0;    // sender holds off while set

  task automatic report_mismatch(input string what, input out_word_t got, input out_word_t exp);
    errors++;
    $display("mismatch %s: got value %h status %0d, expected value %h status %0d",
             what, got.pop_value, got.status, exp.pop_value, exp.status);
  endtask

  // index of the smallest value in the heap shadow
  function automatic int smallest_idx();
    int k;
    k = 0;
    for (int j = 1; j < heap_q.size(); j++)
      if (heap_q[j] < heap_q[k]) k = j;
    return k;
  endfunction

  // works out the result of one accepted word and updates the shadow stores
  function automatic out_word_t queue_step(input in_word_t w);
    out_word_t r;
    int k;
    r = '0;
    case (req_t'(w.req_type))
      REQ_PUSH: begin
        if (fifo_q.size() + heap_q.size() >= CAP) begin
          r.status = ST_FULL;
        end else begin
          fifo_q.insert(fifo_q.size(), w.push_value);
          r.status = ST_ACCEPTED;
        end
      end
      REQ_POP: begin
        if (heap_q.size() > 0) begin
          k = smallest_idx();
          r.pop_value = heap_q[k];
          heap_q.delete(k);
          r.status = ST_POP_OK;
        end else if (fifo_q.size() > 0) begin
          r.pop_value = fifo_q.pop_front();
          r.status = ST_POP_OK;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      default: begin
        // sort and the unused code both move the whole fifo into the heap
        while (fifo_q.size() > 0 && heap_q.size() < CAP)
          heap_q.insert(heap_q.size(), fifo_q.pop_front());
        r.status = ST_ACCEPTED;
      end
    endcase
    return r;
  endfunction

  // driver: a stalled word stays put; a new one only when the last was taken
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          expected_q.insert(expected_q.size(), queue_step(in_data));
          words_sent++;
        end
        if (!hold && pending_q.size() > 0 && (quiet || $urandom_range(99) >= 32)) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each taken result word, then pick the next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", out_data, '0);
        end else begin
          if (out_data !== expected_q[0])
            report_mismatch("field", out_data, expected_q[0]);
          if (out_data.status == ST_FULL) full_seen++;
          if (out_data.status == ST_EMPTY) empty_seen++;
          void'(expected_q.pop_front());
        end
      end
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
    end
  end

  function automatic in_word_t mk(input req_t t, input logic [31:0] v);
    in_word_t w;
    w.req_type = t;
    w.push_value = v;
    return w;
  endfunction

  task automatic add_word(input in_word_t w);
    pending_q.insert(pending_q.size(), w);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int max_push);
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < max_push) add_word(mk(REQ_PUSH, $urandom()));
      else if (r < 88) add_word(mk(REQ_POP, $urandom()));
      else if (r < 97) add_word(mk(REQ_SORT, $urandom()));
      else add_word(mk(REQ_ALT, $urandom()));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, empty sort, extreme values, fifo order, heap order, code 3
    add_word(mk(REQ_POP, 32'hFFFF_FFFF));
    add_word(mk(REQ_SORT, 32'h0));
    add_word(mk(REQ_PUSH, 32'hFFFF_FFFF));
    add_word(mk(REQ_PUSH, 32'h0));
    add_word(mk(REQ_PUSH, 32'h5555_5555));
    add_word(mk(REQ_POP, 32'h0));
    add_word(mk(REQ_SORT, 32'h0));
    add_word(mk(REQ_PUSH, 32'hAAAA_AAAA));
    add_word(mk(REQ_PUSH, 32'h5555_5555));
    add_word(mk(REQ_ALT, 32'hFFFF_FFFF));
    add_word(mk(REQ_POP, 32'h0));
    add_word(mk(REQ_PUSH, 32'h1));
    add_word(mk(REQ_POP, 32'h0));
    add_word(mk(REQ_POP, 32'h0));
    add_word(mk(REQ_POP, 32'h0));
    add_word(mk(REQ_POP, 32'h0));
    add_word(mk(REQ_POP, 32'h0));
    drain();

    // random mix with a hold-off until every result is in
    random_phase(400, 50);
    wait (pending_q.size() <= 200);
    hold = 1'b1;
    @(posedge clk);
    wait (!in_valid && expected_q.size() == 0);
    hold = 1'b0;
    drain();
    // no-idle stretch
    quiet = 1'b1;
    random_phase(300, 50);
    drain();
    quiet = 1'b0;

    // fill to capacity: push-heavy, sorts mixed in, then overflow
    for (int j = 0; j < CAP + 8; j++) begin
      add_word(mk(REQ_PUSH, $urandom()));
      if (j % 97 == 0) add_word(mk(REQ_SORT, 32'h0));
    end
    drain();
    random_phase(250, 30);
    drain();
    hold = 1'b0;

    if (expected_q.size() != 0)
      report_mismatch("missing result", '0, expected_q[0]);

    if (errors == 0) begin
      $display("run: %0d words sent, %0d results checked (%0d full, %0d empty)",
               words_sent, results_seen, full_seen, empty_seen);
      $display("tb_top: PASS");
    end else begin
      $display("run: %0d words sent, %0d results, %0d mismatches",
               words_sent, results_seen, errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // safety net against a hang
  initial begin
    #200ms;
    $display("timeout");
    $display("tb_top: FAIL");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/sfmh_pkg.sv
rtl/core/sfmh_ram.sv
rtl/core/sfmh_datapath.sv
rtl/core/sfmh_ctrl.sv
rtl/core/staged_fifo_min_heap_queue.sv
rtl/core/sfmh_checker.sv
tb/tb_top.sv
